>>> design/dsu_pkg.sv
// Shared types and constants for the union-find core.
`default_nettype none

package dsu_pkg;

    localparam int NODE_W = 10;

    typedef logic [NODE_W-1:0] node_t;

    typedef enum logic {
        OP_FIND  = 1'b0,
        OP_UNION = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FSTART,
        ST_WALK,
        ST_CSTART,
        ST_COMP,
        ST_LINK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic  rd_en;
        node_t rd_addr;
        logic  wr_en;
        node_t wr_addr;
        node_t wr_data;
    } mem_req_t;

endpackage

`default_nettype wire

>>> design/disjoint_set_union_find_core.sv
// Top level of the union-find core: sequencer plus parent table.
// Find walks from node_a to its root and, if node_a is not a root, compresses the path;
//   union does the same for node_b, then writes one link on a merge.
// Throughput: one request at a time, the next taken the cycle after the result loads,
//   which waits while an older result is still held.
// Reset: control clears at once, then NODES entries (at most 1024) clear, 1 per cycle.
`default_nettype none

module disjoint_set_union_find_core #(
    parameter int NODES = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // node_a [9:0], node_b [19:10], zero fill
    input  wire logic [0:0]  s_tuser,   // operation [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // root [9:0], zero fill
    output logic [0:0]       m_tuser    // merged [0]
);
    import dsu_pkg::*;

    localparam int DEPTH = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);

    mem_req_t req;
    node_t    rd_data;

    dsu_ctrl #(
        .NODES (NODES),
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .req      (req),
        .rd_data  (rd_data)
    );

    dsu_parent_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

>>> design/dsu_parent_mem.sv
// Parent table: one write port, one read port with registered read data.
`default_nettype none

module dsu_parent_mem #(
    parameter int DEPTH = 1024
) (
    input  wire logic              clk,
    input  wire dsu_pkg::mem_req_t req,
    output dsu_pkg::node_t         rd_data
);
    import dsu_pkg::*;

    localparam int AW = $clog2(DEPTH);

    node_t mem [DEPTH];
    node_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/dsu_ctrl.sv
// Sequencer: root walk, path compression, link and result register.
`default_nettype none

module dsu_ctrl #(
    parameter int NODES = 1024,
    parameter int DEPTH = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [23:0]       s_tdata,
    input  wire logic [0:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,
    output logic [0:0]             m_tuser,
    output dsu_pkg::mem_req_t      req,
    input  wire dsu_pkg::node_t    rd_data
);
    import dsu_pkg::*;

    localparam int AW = $clog2(DEPTH);

    state_t      state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic        phase_reg, phase_next;
    op_t         op_reg, op_next;
    node_t       a_reg, a_next;
    node_t       b_reg, b_next;
    node_t       cur_reg, cur_next;
    node_t       root_reg, root_next;
    node_t       ra_reg, ra_next;
    logic        merged_reg, merged_next;
    logic        m_valid_reg, m_valid_next;
    node_t       m_root_reg, m_root_next;
    logic        m_merged_reg, m_merged_next;

    node_t       node;
    logic        node_ok;
    logic        a_ok;
    logic        b_ok;
    logic        done;
    node_t       done_root;

    assign node    = phase_reg ? b_reg : a_reg;
    assign node_ok = 32'(node) < NODES;
    assign a_ok    = 32'(a_reg) < NODES;
    assign b_ok    = 32'(b_reg) < NODES;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg    <= phase_next;
        op_reg       <= op_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        cur_reg      <= cur_next;
        root_reg     <= root_next;
        ra_reg       <= ra_next;
        merged_reg   <= merged_next;
        m_root_reg   <= m_root_next;
        m_merged_reg <= m_merged_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        phase_next    = phase_reg;
        op_next       = op_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        cur_next      = cur_reg;
        root_next     = root_reg;
        ra_next       = ra_reg;
        merged_next   = merged_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_root_next   = m_root_reg;
        m_merged_next = m_merged_reg;
        s_tready      = 1'b0;
        req           = '0;
        done          = 1'b0;
        done_root     = root_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = NODE_W'(clr_reg);
                req.wr_data = NODE_W'(clr_reg);
                clr_next    = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next    = op_t'(s_tuser[0]);
                    a_next     = s_tdata[9:0];
                    b_next     = s_tdata[19:10];
                    phase_next = 1'b0;
                    state_next = ST_FSTART;
                end
            end
            ST_FSTART:
            begin
                cur_next = node;
                if (node_ok)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = node;
                    state_next  = ST_WALK;
                end
                else
                begin
                    done      = 1'b1;
                    done_root = node;
                end
            end
            ST_WALK:
            begin
                if (rd_data == cur_reg)
                begin
                    root_next = cur_reg;
                    if (cur_reg == node)
                    begin
                        done      = 1'b1;
                        done_root = cur_reg;
                    end
                    else
                    begin
                        state_next = ST_CSTART;
                    end
                end
                else
                begin
                    cur_next    = rd_data;
                    req.rd_en   = 1'b1;
                    req.rd_addr = rd_data;
                end
            end
            ST_CSTART:
            begin
                cur_next    = node;
                req.rd_en   = 1'b1;
                req.rd_addr = node;
                state_next  = ST_COMP;
            end
            ST_COMP:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = cur_reg;
                req.wr_data = root_reg;
                if (rd_data == root_reg)
                begin
                    done      = 1'b1;
                    done_root = root_reg;
                end
                else
                begin
                    cur_next    = rd_data;
                    req.rd_en   = 1'b1;
                    req.rd_addr = rd_data;
                end
            end
            ST_LINK:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = ra_reg;
                req.wr_data = root_reg;
                merged_next = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_root_next   = root_reg;
                    m_merged_next = merged_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (done)
        begin
            root_next   = done_root;
            merged_next = 1'b0;
            if (!phase_reg)
            begin
                ra_next = done_root;
                if (op_reg == OP_UNION)
                begin
                    phase_next = 1'b1;
                    state_next = ST_FSTART;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            else if (ra_reg != done_root && a_ok && b_ok)
            begin
                state_next = ST_LINK;
            end
            else
            begin
                root_next  = ra_reg;
                state_next = ST_OUT;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_root_reg};
    assign m_tuser  = m_merged_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en && req.rd_en |-> req.wr_addr != req.rd_addr)
        else $error("read and write hit the same entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !m_tvalid && !s_tready)
        else $error("traffic during table clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LINK |-> ra_reg != root_reg && op_reg == OP_UNION)
        else $error("link of equal roots");

endmodule

`default_nettype wire
